// File: src/nrlm_pkg.sv
// Shared constants for the number range list matcher.
`timescale 1ns / 1ps

package nrlm_pkg;

    // Fixed field widths
    localparam int NUM_W      = 31;   // number_to_match register
    localparam int CHAR_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 31;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_LEN    = 4096;
    localparam int DEF_VALUE_BITS = 31;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR = 1'd1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_MATCH   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOSPEC  = 2'd2;

    // Special bytes
    localparam logic [CHAR_W-1:0] CH_TERM  = 8'h00;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

endpackage

// File: src/number_range_list_matcher_top.sv
// Top level of the number range list matcher: byte parser, range check, result register.
`timescale 1ns / 1ps
//
// Usage
//   Input channel (i_in_valid / o_in_ready / i_char_byte) carries one byte of a
//   string per item; byte 0 ends the string. The string reads as
//   [range list][separator][rest]; the range list holds comma-separated
//   inclusive ranges "a", "a-b", "a-", "-b", checked against number_to_match.
//   Output channel (o_out_valid / i_out_ready) gives at most one result per
//   string: status (matched / not matched / no spec) and the offset where the
//   rest of the string begins. Bytes after the result, up to the terminator,
//   give nothing.
//   Configuration: write number_to_match (index 0) or separator_char (index 1)
//   with i_cfg_wr_en; only while no string is in flight.
// Timing
//   One item per cycle sustained while the output is not stalled. A result appears
//   in the output register in the cycle after the byte that causes it is accepted;
//   the parser state and the output register are the only pipeline depth.
// Reset and stall
//   Synchronous active-low reset clears the parser, the configuration registers
//   and the output valid. When the receiver stalls, the pending result holds and the
//   input stops taking bytes: ready is low whenever a result waits and is not
//   being drained, whatever the next byte would do.

module number_range_list_matcher_top #(
    parameter int MAX_LEN    = nrlm_pkg::DEF_MAX_LEN,
    parameter int VALUE_BITS = nrlm_pkg::DEF_VALUE_BITS,
    localparam int OFF_W     = $clog2(MAX_LEN + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write port
    input  logic                         i_cfg_wr_en,
    input  logic [nrlm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [nrlm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // byte input
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [nrlm_pkg::CHAR_W-1:0]  i_char_byte,
    // result output
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [nrlm_pkg::STATUS_W-1:0] o_match_status,
    output logic [OFF_W-1:0]             o_rest_offset
);
    import nrlm_pkg::*;

    // Compare width covers both the register and the parsed bounds
    localparam int CW  = (NUM_W > VALUE_BITS) ? NUM_W : VALUE_BITS;
    localparam int AW  = VALUE_BITS + 4;  // room for acc * 10 + digit
    localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};
    localparam logic [OFF_W-1:0]      MAX_POS   = OFF_W'(MAX_LEN);

    // Parse phases
    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_LOW   = 2'd1;
    localparam logic [1:0] PH_DASH  = 2'd2;
    localparam logic [1:0] PH_HIGH  = 2'd3;

    // Configuration
    logic [NUM_W-1:0]  r_number;
    logic [CHAR_W-1:0] r_separator;

    // Parser state
    logic [1:0]            r_phase,      n_phase;
    logic [VALUE_BITS-1:0] r_low,        n_low;
    logic                  r_low_seen,   n_low_seen;
    logic                  r_dash_seen,  n_dash_seen;
    logic [VALUE_BITS-1:0] r_high,       n_high;
    logic                  r_high_seen,  n_high_seen;
    logic                  r_any_match,  n_any_match;
    logic [OFF_W-1:0]      r_pos,        n_pos;
    logic                  r_result_given, n_result_given;

    // Output register
    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic [OFF_W-1:0]      r_offset, n_offset;
    logic                  emit;

    logic                  accept;
    logic                  is_digit;
    logic [3:0]            digit;
    logic [VALUE_BITS-1:0] acc_in, acc_out;
    logic [AW-1:0]         acc_wide;
    logic [CW-1:0]         num_x, low_x, high_x;
    logic                  hit, lone, any_now;
    logic [OFF_W-1:0]      pos_inc;
    logic [STATUS_W-1:0]   close_status;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign is_digit = (i_char_byte inside {[CH_ZERO:CH_NINE]});
    assign digit    = i_char_byte[3:0];

    // Decimal accumulate with saturation; the phase picks the bound being built,
    // which is zero while its first digit arrives, so one unit serves both bounds.
    assign acc_in   = (r_phase == PH_DASH || r_phase == PH_HIGH) ? r_high : r_low;
    assign acc_wide = (AW'(acc_in) << 3) + (AW'(acc_in) << 1) + AW'(digit);
    assign acc_out  = (acc_wide > AW'(VALUE_MAX)) ? VALUE_MAX : acc_wide[VALUE_BITS-1:0];

    // Close the current element: range check and lone-dash detection
    assign num_x  = CW'(r_number);
    assign low_x  = CW'(r_low);
    assign high_x = CW'(r_high);
    always_comb begin
        hit = 1'b0;
        if (r_low_seen || r_high_seen) begin
            if (!r_dash_seen) begin
                hit = (num_x == low_x);
            end else if (!r_high_seen) begin
                hit = (num_x >= low_x);
            end else if (!r_low_seen) begin
                hit = (num_x <= high_x);
            end else begin
                hit = (num_x >= low_x) && (num_x <= high_x);
            end
        end
    end
    assign lone    = !r_low_seen && !r_high_seen && r_dash_seen;
    assign any_now = r_any_match || hit;
    assign close_status = lone ? ST_NOSPEC : (any_now ? ST_MATCH : ST_NOMATCH);

    assign pos_inc = (r_pos == MAX_POS) ? r_pos : r_pos + 1'b1;

    // Per-byte state update
    always_comb begin
        n_phase        = r_phase;
        n_low          = r_low;
        n_low_seen     = r_low_seen;
        n_dash_seen    = r_dash_seen;
        n_high         = r_high;
        n_high_seen    = r_high_seen;
        n_any_match    = r_any_match;
        n_pos          = pos_inc;
        n_result_given = r_result_given;
        emit           = 1'b0;
        n_status       = ST_NOSPEC;
        n_offset       = '0;

        if (r_result_given) begin
            // swallow the tail; the terminator readies the next string
            if (i_char_byte == CH_TERM) begin
                n_pos          = '0;
                n_any_match    = 1'b0;
                n_result_given = 1'b0;
            end
        end else if (i_char_byte == CH_TERM) begin
            emit     = 1'b1;
            n_status = (r_separator != CH_TERM) ? ST_NOSPEC : close_status;
            n_offset = (n_status == ST_NOSPEC) ? '0 : r_pos;
            n_phase     = PH_START;
            n_low       = '0;
            n_low_seen  = 1'b0;
            n_dash_seen = 1'b0;
            n_high      = '0;
            n_high_seen = 1'b0;
            n_any_match = 1'b0;
            n_pos       = '0;
        end else if (i_char_byte == r_separator) begin
            emit     = 1'b1;
            n_status = close_status;
            n_offset = lone ? '0 : pos_inc;
            n_result_given = 1'b1;
            n_any_match = any_now;
            n_phase     = PH_START;
            n_low       = '0;
            n_low_seen  = 1'b0;
            n_dash_seen = 1'b0;
            n_high      = '0;
            n_high_seen = 1'b0;
        end else if (i_char_byte == CH_COMMA) begin
            // comma closes the element in every phase; a lone dash is an error
            n_phase     = PH_START;
            n_low       = '0;
            n_low_seen  = 1'b0;
            n_dash_seen = 1'b0;
            n_high      = '0;
            n_high_seen = 1'b0;
            n_any_match = any_now;
            if (lone) begin
                emit           = 1'b1;
                n_result_given = 1'b1;
            end
        end else if (is_digit) begin
            case (r_phase)
                PH_START, PH_LOW: begin
                    n_low      = acc_out;
                    n_low_seen = 1'b1;
                    n_phase    = PH_LOW;
                end
                PH_DASH, PH_HIGH: begin
                    n_high      = acc_out;
                    n_high_seen = 1'b1;
                    n_phase     = PH_HIGH;
                end
                default: begin
                    n_phase = PH_START;
                end
            endcase
        end else if (i_char_byte == CH_DASH &&
                     (r_phase == PH_START || r_phase == PH_LOW)) begin
            n_dash_seen = 1'b1;
            n_phase     = PH_DASH;
        end else begin
            // stray byte: report no spec at once and drop the element
            emit           = 1'b1;
            n_result_given = 1'b1;
            n_phase     = PH_START;
            n_low       = '0;
            n_low_seen  = 1'b0;
            n_dash_seen = 1'b0;
            n_high      = '0;
            n_high_seen = 1'b0;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number    <= '0;
            r_separator <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_NUMBER:    r_number    <= i_cfg_data[NUM_W-1:0];
                CFG_SEPARATOR: r_separator <= i_cfg_data[CHAR_W-1:0];
                default: ;
            endcase
        end
    end

    // Parser state, advanced on every accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_START;
            r_low          <= '0;
            r_low_seen     <= 1'b0;
            r_dash_seen    <= 1'b0;
            r_high         <= '0;
            r_high_seen    <= 1'b0;
            r_any_match    <= 1'b0;
            r_pos          <= '0;
            r_result_given <= 1'b0;
        end else if (accept) begin
            r_phase        <= n_phase;
            r_low          <= n_low;
            r_low_seen     <= n_low_seen;
            r_dash_seen    <= n_dash_seen;
            r_high         <= n_high;
            r_high_seen    <= n_high_seen;
            r_any_match    <= n_any_match;
            r_pos          <= n_pos;
            r_result_given <= n_result_given;
        end
    end

    // Result register: load on emit, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_status <= n_status;
            r_offset <= n_offset;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_match_status = r_status;
    assign o_rest_offset  = r_offset;

    // A no-spec result never carries an offset
    a_nospec_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_match_status == ST_NOSPEC) |-> (o_rest_offset == '0))
        else $error("no-spec result with nonzero offset");

    // Offset never passes the maximum string length
    a_offset_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_rest_offset <= MAX_POS))
        else $error("rest offset above maximum length");

    // Once the result is out, the element state stays cleared
    a_given_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_result_given |-> (r_phase == PH_START && !r_low_seen && !r_high_seen
                            && !r_dash_seen))
        else $error("element state live after result given");

    // A terminator readies the block for the next string
    a_term_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_char_byte == CH_TERM) |=> (r_pos == '0 && !r_result_given))
        else $error("terminator did not restart the string");

endmodule
